// ===== rtl/fault_record_table_unit_assert.svh =====
// fault_record_table_unit_assert.svh: assertion macros for the fault log
// used by fault_record_table_unit; expects clk and rst_n in scope
`ifndef FAULT_RECORD_TABLE_UNIT_ASSERT_SVH
`define FAULT_RECORD_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define FRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FRT_ASSERT(lbl, prop, msg)
`define FRT_ASSERT_IMP(lbl, ante, cons, msg)
`define FRT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/frt_pkg.sv =====
// frt_pkg: types, codes and helpers for the fault record table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frt_pkg;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int NUM_MODULES = 16;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_INIT  = 2'd1;
  localparam logic [1:0] ST_BAD_PARAM = 2'd2;

  typedef enum logic [2:0] {
    MODE_INIT   = 3'd0,
    MODE_DEINIT = 3'd1,
    MODE_RAISE  = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_CLRALL = 3'd4,
    MODE_CHECK  = 3'd5,
    MODE_READ   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] code;
    logic [3:0]         src_module;
    logic [31:0]        timestamp;
    logic [3:0]         index;
  } frt_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         cleared_total;
    logic               found;
    logic signed [15:0] last_code;
    logic [4:0]         active_total;
    logic               any_active;
    logic signed [15:0] rec_code;
    logic [3:0]         rec_module;
    logic [31:0]        rec_time;
    logic               rec_cleared;
  } frt_out_t;

  typedef struct packed {
    logic signed [15:0] code;
    logic [3:0]         src_module;
    logic [31:0]        stamp;
    logic               cleared;
  } frt_entry_t;

  function automatic logic raise_ok(frt_in_t it);
    return (it.code != 16'sd0) && (int'(it.src_module) < NUM_MODULES);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/frt_ram.sv =====
// frt_ram: single-port-write, single-port-read entry memory, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module frt_ram #(
  parameter int DEPTH = 16,
  parameter int DW    = 53
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DW-1:0]                          wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DW-1:0]                          rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/fault_record_table_unit.sv =====
// fault_record_table_unit: fixed-depth fault log with command interface
// depends on frt_pkg, frt_ram and fault_record_table_unit_assert.svh
//
//   channel   ports                          handshake
//   input     start, busy, in_item           start & !busy
//   result    out_valid, out_result          one-cycle strobe, no back pressure
//   config    cfg_valid, cfg_ready, cfg_data cfg_valid & cfg_ready (idle only)
//
// raise, clear code, clear all and check walk the entries below the fill count
// through the one memory read port, one entry a cycle; a raise or check that
// hits stops the walk early.
// init, deinit, read record and rejected commands go straight to the done state.
// the result strobe comes the cycle after the last busy cycle.
// reset clears control state only; entries are valid below the fill count.
`timescale 1ns / 1ps
`default_nettype none
`include "fault_record_table_unit_assert.svh"

module fault_record_table_unit #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  frt_pkg::frt_in_t                 in_item,
  output logic                             out_valid,
  output frt_pkg::frt_out_t                out_result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [frt_pkg::CAP_W-1:0]        cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 4) ? CW : 4;
  localparam int DW = $bits(frt_pkg::frt_entry_t);

  frt_pkg::fsm_t             state_r, state_nxt;
  frt_pkg::frt_in_t          cmd_r, cmd_nxt;
  logic [frt_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0]             held_r, held_nxt;
  logic [CW-1:0]             fill_r, fill_nxt;
  logic [CW-1:0]             act_r, act_nxt;
  logic signed [15:0]        last_r, last_nxt;
  logic                      ready_r, ready_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      dv_r, dv_nxt;
  logic [AW-1:0]             dpos_r, dpos_nxt;
  logic                      hit_r, hit_nxt;
  logic                      free_ok_r, free_ok_nxt;
  logic [AW-1:0]             free_pos_r, free_pos_nxt;
  logic [CW-1:0]             clr_r, clr_nxt;
  logic                      out_valid_r, out_valid_nxt;
  frt_pkg::frt_out_t         out_r, out_nxt;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  frt_pkg::frt_entry_t       mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [DW-1:0]             mem_rdata;
  frt_pkg::frt_entry_t       ent;

  logic [XW-1:0]             in_idx_w, cmd_idx_w;
  logic                      scan_go, read_go, match, stop;
  logic [1:0]                st;

  frt_ram #(
    .DEPTH (DEPTH),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign ent       = frt_pkg::frt_entry_t'(mem_rdata);
  assign in_idx_w  = XW'(in_item.index);
  assign cmd_idx_w = XW'(cmd_r.index);
  assign busy      = (state_r != frt_pkg::S_IDLE);
  assign cfg_ready = (state_r == frt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_result = out_r;

  assign scan_go = ready_r &&
                   ((in_item.mode == frt_pkg::MODE_RAISE && frt_pkg::raise_ok(in_item)) ||
                    (in_item.mode inside {frt_pkg::MODE_CLEAR, frt_pkg::MODE_CLRALL,
                                          frt_pkg::MODE_CHECK}));
  assign read_go = ready_r && (in_item.mode == frt_pkg::MODE_READ) &&
                   (in_idx_w < XW'(fill_r));
  assign match   = dv_r && (ent.code == cmd_r.code) && !ent.cleared;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    held_nxt      = held_r;
    fill_nxt      = fill_r;
    act_nxt       = act_r;
    last_nxt      = last_r;
    ready_nxt     = ready_r;
    cnt_nxt       = cnt_r;
    dv_nxt        = 1'b0;
    dpos_nxt      = dpos_r;
    hit_nxt       = hit_r;
    free_ok_nxt   = free_ok_r;
    free_pos_nxt  = free_pos_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = dpos_r;
    mem_wdata     = ent;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r[AW-1:0];
    stop          = 1'b0;
    st            = frt_pkg::ST_OK;

    case (state_r)
      frt_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_item;
          cnt_nxt     = '0;
          hit_nxt     = 1'b0;
          free_ok_nxt = 1'b0;
          clr_nxt     = '0;
          if (scan_go) begin
            state_nxt = frt_pkg::S_SCAN;
          end else begin
            if (read_go) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(in_idx_w);
            end
            state_nxt = frt_pkg::S_DONE;
          end
        end
      end

      frt_pkg::S_SCAN: begin
        // read of entry cnt overlaps the write-back of entry cnt-1
        if (cnt_r < fill_r) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r[AW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          dv_nxt    = 1'b1;
          dpos_nxt  = cnt_r[AW-1:0];
        end
        if (dv_r) begin
          case (cmd_r.mode)
            frt_pkg::MODE_RAISE: begin
              if (match) begin
                mem_we          = 1'b1;
                mem_wdata.stamp = cmd_r.timestamp;
                hit_nxt         = 1'b1;
                stop            = 1'b1;
              end else if (ent.cleared && !free_ok_r) begin
                free_ok_nxt  = 1'b1;
                free_pos_nxt = dpos_r;
              end
            end
            frt_pkg::MODE_CLEAR: begin
              if (match) begin
                mem_we            = 1'b1;
                mem_wdata.cleared = 1'b1;
                clr_nxt           = clr_r + 1'b1;
                if (act_r != '0) begin
                  act_nxt = act_r - 1'b1;
                end
              end
            end
            frt_pkg::MODE_CLRALL: begin
              if (!ent.cleared) begin
                mem_we            = 1'b1;
                mem_wdata.cleared = 1'b1;
                clr_nxt           = clr_r + 1'b1;
              end
            end
            frt_pkg::MODE_CHECK: begin
              if (match) begin
                hit_nxt = 1'b1;
                stop    = 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (stop || (cnt_r == fill_r)) begin
          state_nxt = frt_pkg::S_DONE;
        end
      end

      frt_pkg::S_DONE: begin
        out_nxt = '0;
        case (cmd_r.mode)
          frt_pkg::MODE_INIT: begin
            if (cap_r == '0) begin
              st = frt_pkg::ST_BAD_PARAM;
            end else begin
              fill_nxt  = '0;
              act_nxt   = '0;
              last_nxt  = '0;
              held_nxt  = (int'(cap_r) > DEPTH) ? CW'(DEPTH) : CW'(cap_r);
              ready_nxt = 1'b1;
            end
          end
          frt_pkg::MODE_DEINIT: begin
            if (ready_r) begin
              fill_nxt  = '0;
              act_nxt   = '0;
              last_nxt  = '0;
              ready_nxt = 1'b0;
            end
          end
          frt_pkg::MODE_RAISE: begin
            if (!ready_r) begin
              st = frt_pkg::ST_NOT_INIT;
            end else if (!frt_pkg::raise_ok(cmd_r)) begin
              st = frt_pkg::ST_BAD_PARAM;
            end else begin
              last_nxt = cmd_r.code;
              if (!hit_r) begin
                mem_we               = 1'b1;
                mem_wdata.code       = cmd_r.code;
                mem_wdata.src_module = cmd_r.src_module;
                mem_wdata.stamp      = cmd_r.timestamp;
                mem_wdata.cleared    = 1'b0;
                if (fill_r >= held_r) begin
                  if (free_ok_r) begin
                    mem_waddr = free_pos_r;
                    act_nxt   = act_r + 1'b1;
                  end else begin
                    // full of active entries: entry 0 is replaced, count unchanged
                    mem_waddr = '0;
                    if (act_r == '0) begin
                      act_nxt = act_r + 1'b1;
                    end
                  end
                end else begin
                  mem_waddr = fill_r[AW-1:0];
                  fill_nxt  = fill_r + 1'b1;
                  act_nxt   = act_r + 1'b1;
                end
              end
            end
          end
          frt_pkg::MODE_CLEAR: begin
            if (!ready_r) begin
              st = frt_pkg::ST_NOT_INIT;
            end else if ((last_r == cmd_r.code) && (act_r == '0)) begin
              last_nxt = '0;
            end
          end
          frt_pkg::MODE_CLRALL: begin
            if (!ready_r) begin
              st = frt_pkg::ST_NOT_INIT;
            end else begin
              act_nxt  = '0;
              last_nxt = '0;
            end
          end
          frt_pkg::MODE_CHECK: begin
            if (!ready_r) begin
              st = frt_pkg::ST_NOT_INIT;
            end else begin
              out_nxt.found = hit_r;
            end
          end
          frt_pkg::MODE_READ: begin
            if (!ready_r || (cmd_idx_w >= XW'(fill_r))) begin
              st = frt_pkg::ST_BAD_PARAM;
            end else begin
              out_nxt.rec_code    = ent.code;
              out_nxt.rec_module  = ent.src_module;
              out_nxt.rec_time    = ent.stamp;
              out_nxt.rec_cleared = ent.cleared;
            end
          end
          default: begin
            st = frt_pkg::ST_BAD_PARAM;
          end
        endcase
        out_nxt.status        = st;
        out_nxt.cleared_total = 5'(clr_r);
        out_nxt.last_code     = last_nxt;
        out_nxt.active_total  = 5'(act_nxt);
        out_nxt.any_active    = (act_nxt != '0);
        out_valid_nxt         = 1'b1;
        state_nxt             = frt_pkg::S_IDLE;
      end

      default: begin
        state_nxt = frt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frt_pkg::S_IDLE;
      cap_r       <= frt_pkg::CAP_RESET;
      held_r      <= '0;
      fill_r      <= '0;
      act_r       <= '0;
      last_r      <= '0;
      ready_r     <= 1'b0;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      hit_r       <= 1'b0;
      free_ok_r   <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      held_r      <= held_nxt;
      fill_r      <= fill_nxt;
      act_r       <= act_nxt;
      last_r      <= last_nxt;
      ready_r     <= ready_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      hit_r       <= hit_nxt;
      free_ok_r   <= free_ok_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    dpos_r     <= dpos_nxt;
    free_pos_r <= free_pos_nxt;
    out_r      <= out_nxt;
  end

  `FRT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command left block idle")
  `FRT_ASSERT_IMP(a_out_from_done, out_valid, $past(state_r == frt_pkg::S_DONE), "stray result beat")
  `FRT_ASSERT(a_act_le_fill, act_r <= fill_r, "active count above fill count")
  `FRT_ASSERT(a_fill_le_cap, fill_r <= held_r, "fill count above held capacity")
  `FRT_ASSERT_IMP(a_idle_no_write, state_r == frt_pkg::S_IDLE, !mem_we, "entry write while idle")
  `FRT_ASSERT_IMP(a_down_empty, !ready_r, fill_r == '0, "entries held while not initialized")

endmodule

`default_nettype wire
